// ===== hw/rtl/dnc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and fixed constants for the dominance negative cache.
// No dependencies.
package dnc_pkg;

    localparam int COORD_IN_W = 16;
    localparam int NUM_COORD_IN = 4;
    localparam int S_DATA_W = COORD_IN_W * NUM_COORD_IN;
    localparam int CNT_OUT_W = 5;
    localparam int M_DATA_W = 8;
    localparam int CFG_W = 3;
    localparam logic [CFG_W-1:0] DIMS_RESET = 3'd4;

    typedef enum logic {
        MODE_LOOKUP = 1'b0,
        MODE_INSERT = 1'b1
    } dnc_mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FINISH
    } dnc_state_t;

endpackage

// ===== hw/rtl/dominance_negative_cache.sv =====
`timescale 1ns / 1ps
// Top level of the dominance negative cache: point table, walk sequencer and compare unit.
// Depends on dnc_pkg.
//
//  channel   direction  payload
//  s_*       in         tuser: mode; tdata: coord_0..coord_3 (16 bits each)
//  m_*       out        tdata: covered, overflow, entry_count, one pad bit
//  cfg_*     in         data: dims_in_use
//
// For each request the sequencer reads one table slot per cycle through the registered
// memory port and the single compare unit checks it in the next cycle; the finish state
// then stores an inserted point in a free slot and issues the result.
// Reset clears the valid bits, so the table is empty and dims_in_use is 4 at once.
// The result waits in an output register; a stalled result holds the final cycle only.
module dominance_negative_cache #(
    parameter int DEPTH = 16,
    parameter int DIMS = 4,
    parameter int COORD_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [dnc_pkg::S_DATA_W-1:0]  s_tdata,  // coord_0, coord_1, coord_2, coord_3
    input  logic                          s_tuser,  // mode
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [dnc_pkg::M_DATA_W-1:0]  m_tdata,  // covered, overflow, entry_count[4:0], 0
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [dnc_pkg::CFG_W-1:0]     cfg_data  // dims_in_use
);
    import dnc_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int PT_W = DIMS * COORD_BITS;

    dnc_state_t state_reg, state_next;
    logic [CFG_W-1:0] dims_reg, dims_next;
    logic [DEPTH-1:0] valid_reg, valid_next;
    logic [PT_W-1:0] pt_reg, pt_next;
    logic [DIMS-1:0] act_reg, act_next;
    logic mode_reg, mode_next;
    logic [CNT_W-1:0] rd_cnt_reg, rd_cnt_next;
    logic cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0] cmp_idx_reg, cmp_idx_next;
    logic covered_reg, covered_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic free_found_reg, free_found_next;
    logic [IDX_W-1:0] free_idx_reg, free_idx_next;
    logic m_tvalid_reg, m_tvalid_next;
    logic m_covered_reg, m_covered_next;
    logic m_overflow_reg, m_overflow_next;
    logic [CNT_OUT_W-1:0] m_count_reg, m_count_next;

    logic [PT_W-1:0] entry_mem [DEPTH];
    logic [PT_W-1:0] rd_data_reg;
    logic rd_en;
    logic wr_en;
    logic [CFG_W-1:0] dims_eff;
    logic signed [COORD_BITS-1:0] p_c [DIMS];
    logic signed [COORD_BITS-1:0] e_c [DIMS];
    logic ge_all;
    logic le_all;
    logic slot_valid;
    logic post_valid;
    logic [CNT_W-1:0] count_fin;
    logic [CNT_W+CNT_OUT_W-1:0] count_ext;

    assign s_tready = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = {1'b0, m_count_reg, m_overflow_reg, m_covered_reg};

    always_comb begin
        if (dims_reg == '0) begin
            dims_eff = CFG_W'(1);
        end else if (dims_reg > CFG_W'(DIMS)) begin
            dims_eff = CFG_W'(DIMS);
        end else begin
            dims_eff = dims_reg;
        end
    end

    // Compare unit: one stored entry against the held point per cycle.
    always_comb begin
        ge_all = 1'b1;
        le_all = 1'b1;
        for (int j = 0; j < DIMS; j++) begin
            p_c[j] = pt_reg[j*COORD_BITS +: COORD_BITS];
            e_c[j] = rd_data_reg[j*COORD_BITS +: COORD_BITS];
            if (act_reg[j] && (e_c[j] < p_c[j])) begin
                ge_all = 1'b0;
            end
            if (act_reg[j] && (p_c[j] < e_c[j])) begin
                le_all = 1'b0;
            end
        end
    end

    assign slot_valid = valid_reg[cmp_idx_reg];
    assign post_valid = slot_valid && !((mode_reg == MODE_INSERT) && le_all);
    assign count_fin = count_reg + CNT_W'(1);

    always_comb begin
        state_next = state_reg;
        dims_next = dims_reg;
        valid_next = valid_reg;
        pt_next = pt_reg;
        act_next = act_reg;
        mode_next = mode_reg;
        rd_cnt_next = rd_cnt_reg;
        cmp_vld_next = 1'b0;
        cmp_idx_next = cmp_idx_reg;
        covered_next = covered_reg;
        count_next = count_reg;
        free_found_next = free_found_reg;
        free_idx_next = free_idx_reg;
        m_tvalid_next = m_tvalid_reg;
        m_covered_next = m_covered_reg;
        m_overflow_next = m_overflow_reg;
        m_count_next = m_count_reg;
        rd_en = 1'b0;
        wr_en = 1'b0;
        count_ext = '0;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (cfg_valid) begin
            dims_next = cfg_data;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    for (int j = 0; j < DIMS; j++) begin
                        pt_next[j*COORD_BITS +: COORD_BITS] =
                            s_tdata[j*COORD_IN_W +: COORD_BITS];
                        act_next[j] = CFG_W'(j) < dims_eff;
                    end
                    mode_next = s_tuser;
                    rd_cnt_next = '0;
                    covered_next = 1'b0;
                    count_next = '0;
                    free_found_next = 1'b0;
                    free_idx_next = '0;
                    state_next = ST_WALK;
                end
            end
            ST_WALK: begin
                if (rd_cnt_reg != CNT_W'(DEPTH)) begin
                    rd_en = 1'b1;
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = rd_cnt_reg[IDX_W-1:0];
                    rd_cnt_next = rd_cnt_reg + CNT_W'(1);
                end
                if (cmp_vld_reg) begin
                    if ((mode_reg == MODE_LOOKUP) && slot_valid && ge_all) begin
                        covered_next = 1'b1;
                    end
                    if (!post_valid) begin
                        valid_next[cmp_idx_reg] = 1'b0;
                        if (!free_found_reg) begin
                            free_found_next = 1'b1;
                            free_idx_next = cmp_idx_reg;
                        end
                    end else begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end else if (rd_cnt_reg == CNT_W'(DEPTH)) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_covered_next = (mode_reg == MODE_LOOKUP) && covered_reg;
                    m_overflow_next = (mode_reg == MODE_INSERT) && !free_found_reg;
                    count_ext = {{CNT_OUT_W{1'b0}}, count_reg};
                    if ((mode_reg == MODE_INSERT) && free_found_reg) begin
                        wr_en = 1'b1;
                        valid_next[free_idx_reg] = 1'b1;
                        count_ext = {{CNT_OUT_W{1'b0}}, count_fin};
                    end
                    m_count_next = count_ext[CNT_OUT_W-1:0];
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            dims_reg <= DIMS_RESET;
            valid_reg <= '0;
            cmp_vld_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            dims_reg <= dims_next;
            valid_reg <= valid_next;
            cmp_vld_reg <= cmp_vld_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pt_reg <= pt_next;
        act_reg <= act_next;
        mode_reg <= mode_next;
        rd_cnt_reg <= rd_cnt_next;
        cmp_idx_reg <= cmp_idx_next;
        covered_reg <= covered_next;
        count_reg <= count_next;
        free_found_reg <= free_found_next;
        free_idx_reg <= free_idx_next;
        m_covered_reg <= m_covered_next;
        m_overflow_reg <= m_overflow_next;
        m_count_reg <= m_count_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            entry_mem[free_idx_reg] <= pt_reg;
        end
        if (rd_en) begin
            rd_data_reg <= entry_mem[rd_cnt_reg[IDX_W-1:0]];
        end
    end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for dominance_negative_cache: directed table then random bursts,
// each reply compared against its literal value or an in-bench archive predictor. Depends on dnc_pkg and the RTL.
module tb_top;
    import dnc_pkg::*;

    localparam int CACHE_DEPTH = 16;
    localparam int CACHE_DIMS = 4;
    localparam int PHASE_ITEMS = 135;
    localparam int CYCLE_LIMIT = 400000;

    typedef logic [NUM_COORD_IN-1:0][COORD_IN_W-1:0] point_t;

    typedef struct packed {
        logic       covered;
        logic       overflow;
        logic [4:0] count;
    } cache_reply_t;

    typedef struct {
        dnc_mode_t    mode;
        point_t       pt;
        bit           literal;
        cache_reply_t reply;
    } probe_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata = '0;
    logic                 s_tuser = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_DATA_W-1:0]  m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_W-1:0]     cfg_data = '0;

    point_t         archive_pts [CACHE_DEPTH];
    bit             archive_valid [CACHE_DEPTH];
    logic [CFG_W-1:0] dims_cfg;
    cache_reply_t   pending_replies [$];
    probe_row_t     probes [$];
    int             fault_count = 0;
    int             cycle_count = 0;

    dominance_negative_cache #(
        .DEPTH(CACHE_DEPTH),
        .DIMS(CACHE_DIMS),
        .COORD_BITS(COORD_IN_W)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    initial begin
        forever begin
            #4 aclk = ~aclk;
        end
    end

    // True when lo is at most hi in each of the first d coordinates.
    function automatic bit dominates(point_t hi, point_t lo, int d);
        for (int k = 0; k < d; k++) begin
            if ($signed(hi[k]) < $signed(lo[k])) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic cache_reply_t absorb_point(dnc_mode_t mode, point_t p);
        cache_reply_t r;
        int d;
        int slot;
        r = '0;
        d = (dims_cfg == 0) ? 1 : (dims_cfg > CACHE_DIMS) ? CACHE_DIMS : int'(dims_cfg);
        if (mode == MODE_LOOKUP) begin
            for (int i = 0; i < CACHE_DEPTH; i++) begin
                if (archive_valid[i] && dominates(archive_pts[i], p, d)) begin
                    r.covered = 1'b1;
                end
            end
        end else begin
            for (int i = 0; i < CACHE_DEPTH; i++) begin
                if (archive_valid[i] && dominates(p, archive_pts[i], d)) begin
                    archive_valid[i] = 1'b0;
                end
            end
            slot = -1;
            for (int i = CACHE_DEPTH - 1; i >= 0; i--) begin
                if (!archive_valid[i]) begin
                    slot = i;
                end
            end
            if (slot < 0) begin
                r.overflow = 1'b1;
            end else begin
                archive_pts[slot] = p;
                archive_valid[slot] = 1'b1;
            end
        end
        for (int i = 0; i < CACHE_DEPTH; i++) begin
            r.count = r.count + 5'(archive_valid[i]);
        end
        return r;
    endfunction

    function automatic logic [COORD_IN_W-1:0] pick_coord();
        int k;
        k = $urandom_range(0, 9);
        if (k == 0) begin
            return COORD_IN_W'($urandom);
        end else if (k == 1) begin
            case ($urandom_range(0, 3))
                0: return 16'h8000;
                1: return 16'h7FFF;
                2: return 16'h0000;
                default: return 16'hFFFF;
            endcase
        end
        return COORD_IN_W'(int'($urandom_range(0, 8)) - 4);
    endfunction

    task automatic add_probe(dnc_mode_t mode, point_t pt, bit literal, cache_reply_t reply);
        probe_row_t row;
        row.mode = mode;
        row.pt = pt;
        row.literal = literal;
        row.reply = reply;
        probes.insert(probes.size(), row);
    endtask

    task automatic offer_point(dnc_mode_t mode, point_t p, bit literal, cache_reply_t lit);
        cache_reply_t r;
        @(negedge aclk);
        s_tuser <= mode;
        s_tdata <= p;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        r = absorb_point(mode, p);
        pending_replies.insert(pending_replies.size(), literal ? lit : r);
    endtask

    task automatic hold_input(int n);
        repeat (n) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
    endtask

    task automatic drain_replies();
        while (pending_replies.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic set_dims(logic [CFG_W-1:0] v);
        hold_input(1);
        drain_replies();
        repeat (CACHE_DEPTH + 8) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge aclk);
        while (!cfg_ready) begin
            @(posedge aclk);
        end
        dims_cfg = v;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("** dominance_negative_cache: FAILED **");
            $finish;
        end
    end

    always @(posedge aclk) begin
        cache_reply_t got;
        cache_reply_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.covered = m_tdata[0];
            got.overflow = m_tdata[1];
            got.count = m_tdata[6:2];
            if (pending_replies.size() == 0) begin
                fault_count++;
                if (fault_count <= 10) begin
                    $display("unexpected reply covered=%0d overflow=%0d count=%0d",
                             got.covered, got.overflow, got.count);
                end
            end else begin
                want = pending_replies[0];
                pending_replies.delete(0);
                if (got.covered !== want.covered || got.overflow !== want.overflow ||
                    got.count !== want.count) begin
                    fault_count++;
                    if (fault_count <= 10) begin
                        $display("mismatch: expected covered=%0d overflow=%0d count=%0d, %s",
                                 want.covered, want.overflow, want.count,
                                 $sformatf("got covered=%0d overflow=%0d count=%0d",
                                           got.covered, got.overflow, got.count));
                    end
                end
            end
        end
    end

    initial begin
        int kind;
        int len;
        bit holdoff_done;
        holdoff_done = 1'b0;
        forever begin
            if (!holdoff_done && cycle_count > 2500) begin
                repeat (400) begin
                    @(negedge aclk);
                    m_tready <= 1'b0;
                end
                holdoff_done = 1'b1;
            end else begin
                kind = $urandom_range(0, 3);
                len = $urandom_range(10, 60);
                for (int i = 0; i < len; i++) begin
                    @(negedge aclk);
                    case (kind)
                        0: m_tready <= 1'b1;
                        1: m_tready <= 1'($urandom_range(0, 1));
                        2: m_tready <= ($urandom_range(0, 3) == 0);
                        default: m_tready <= (i % 3 != 2);
                    endcase
                end
            end
        end
    end

    initial begin
        logic [CFG_W-1:0] dims_plan [8];
        point_t       p;
        cache_reply_t none;
        dnc_mode_t    mode;
        int           sent;
        int           burst;
        bit           drained;

        dims_plan = '{3'd0, 3'd7, 3'd1, 3'd2, 3'd3, 3'd5, 3'd6, 3'd4};
        none = '0;
        for (int i = 0; i < CACHE_DEPTH; i++) begin
            archive_valid[i] = 1'b0;
            archive_pts[i] = '0;
        end
        dims_cfg = DIMS_RESET;

        add_probe(MODE_LOOKUP, {4{16'h8000}}, 1'b1, '{1'b0, 1'b0, 5'd0});
        add_probe(MODE_INSERT, {4{16'h7FFF}}, 1'b1, '{1'b0, 1'b0, 5'd1});
        add_probe(MODE_LOOKUP, {4{16'h7FFF}}, 1'b1, '{1'b1, 1'b0, 5'd1});
        add_probe(MODE_LOOKUP, {4{16'h8000}}, 1'b1, '{1'b1, 1'b0, 5'd1});
        add_probe(MODE_INSERT, {4{16'h8000}}, 1'b1, '{1'b0, 1'b0, 5'd2});
        add_probe(MODE_INSERT, {4{16'h7FFF}}, 1'b1, '{1'b0, 1'b0, 5'd1});
        add_probe(MODE_LOOKUP, {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000}, 1'b0, none);
        for (int i = 0; i < 15; i++) begin
            add_probe(MODE_INSERT, {16'h0, 16'h0, 16'(15 - i), 16'(i)}, 1'b0, none);
        end
        add_probe(MODE_INSERT, {16'h0, 16'h0, 16'h0, 16'd15}, 1'b1, '{1'b0, 1'b1, 5'd16});
        add_probe(MODE_LOOKUP, {16'h0, 16'h0, 16'h0, 16'd15}, 1'b0, none);
        add_probe(MODE_LOOKUP, {16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA}, 1'b0, none);
        add_probe(MODE_INSERT, {4{16'h7FFF}}, 1'b1, '{1'b0, 1'b0, 5'd1});

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (probes[i]) begin
            offer_point(probes[i].mode, probes[i].pt, probes[i].literal, probes[i].reply);
            if ($urandom_range(0, 2) == 0) begin
                hold_input($urandom_range(1, 6));
            end
        end

        foreach (dims_plan[ph]) begin
            set_dims(dims_plan[ph]);
            sent = 0;
            drained = 1'b0;
            while (sent < PHASE_ITEMS) begin
                burst = $urandom_range(1, 16);
                for (int j = 0; j < burst && sent < PHASE_ITEMS; j++) begin
                    for (int k = 0; k < NUM_COORD_IN; k++) begin
                        p[k] = pick_coord();
                    end
                    mode = ($urandom_range(0, 99) < 45) ? MODE_INSERT : MODE_LOOKUP;
                    offer_point(mode, p, 1'b0, none);
                    sent++;
                end
                if (!drained && sent >= PHASE_ITEMS / 2) begin
                    hold_input(1);
                    drain_replies();
                    drained = 1'b1;
                end else if ($urandom_range(0, 3) != 0) begin
                    hold_input($urandom_range(1, 12));
                end
            end
        end

        hold_input(1);
        drain_replies();
        repeat (CACHE_DEPTH + 24) @(posedge aclk);
        if (fault_count == 0) begin
            $display("** dominance_negative_cache: PASSED **");
        end else begin
            $display("** dominance_negative_cache: FAILED **");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/dnc_pkg.sv
hw/rtl/dominance_negative_cache.sv
sim/tb_top.sv
